/* rtl/core/dbnc_pkg.sv */
// Shared constants, register codes and types for the multi-switch debouncer.
// No dependencies; imported by every module of the core.
package dbnc_pkg;

    // Switch table size and derived address width
    localparam int NUM_SWITCHES = 16;
    localparam int ADDR_W       = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    // Field widths
    localparam int IDX_W  = 4;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_FIELD_W  = IDX_W + 1 + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W  = 1 + 1 + IDX_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_BUTTON   = 2'd1;
    localparam logic [1:0] REG_PULLUP   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;

    // Configuration seen by the update logic
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] button_mask;
        logic [CFG_W-1:0] pullup_mask;
    } dbnc_cfg_t;

    // One entry of the per-switch state table
    typedef struct packed {
        logic              status;
        logic              pending;
        logic [TIME_W-1:0] start_time;
    } dbnc_entry_t;

endpackage

/* rtl/core/dbnc_cfg_regs.sv */
// APB register file: debounce period, button mask, pull-up mask.
// Depends on dbnc_pkg.
module dbnc_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbnc_pkg::APB_AW-1:0] paddr,
    input  logic [dbnc_pkg::APB_DW-1:0] pwdata,
    output logic [dbnc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output dbnc_pkg::dbnc_cfg_t        cfg
);
    import dbnc_pkg::*;

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] button_reg;
    logic [CFG_W-1:0] pullup_reg;
    logic             wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
            button_reg   <= '0;
            pullup_reg   <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DEBOUNCE: debounce_reg <= pwdata[CFG_W-1:0];
                REG_BUTTON:   button_reg   <= pwdata[CFG_W-1:0];
                REG_PULLUP:   pullup_reg   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_sel)
            REG_DEBOUNCE: prdata = {{(APB_DW-CFG_W){1'b0}}, debounce_reg};
            REG_BUTTON:   prdata = {{(APB_DW-CFG_W){1'b0}}, button_reg};
            REG_PULLUP:   prdata = {{(APB_DW-CFG_W){1'b0}}, pullup_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.debounce_ms = debounce_reg;
    assign cfg.button_mask = button_reg;
    assign cfg.pullup_mask = pullup_reg;

endmodule

/* rtl/core/dbnc_state_ram.sv */
// Per-switch state table: one write port, one registered read port.
// Entries never written since reset read as zero. Depends on dbnc_pkg.
module dbnc_state_ram (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [dbnc_pkg::ADDR_W-1:0] rd_addr,
    output dbnc_pkg::dbnc_entry_t       rd_data,
    input  logic                        wr_en,
    input  logic [dbnc_pkg::ADDR_W-1:0] wr_addr,
    input  dbnc_pkg::dbnc_entry_t       wr_data
);
    import dbnc_pkg::*;

    dbnc_entry_t             mem_reg [NUM_SWITCHES];
    logic [NUM_SWITCHES-1:0] valid_reg;
    dbnc_entry_t             rd_data_reg;
    logic                    rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Written-since-reset flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/dbnc_update.sv */
// Next-state logic for one switch: toggle and button rules.
// Depends on dbnc_pkg.
module dbnc_update (
    input  dbnc_pkg::dbnc_cfg_t             cfg,
    input  dbnc_pkg::dbnc_entry_t           cur,
    input  logic [dbnc_pkg::IDX_W-1:0]      idx,
    input  logic                            pin_level,
    input  logic [dbnc_pkg::TIME_W-1:0]     now_ms,
    output dbnc_pkg::dbnc_entry_t           nxt,
    output logic                            switched,
    output logic                            switch_state
);
    import dbnc_pkg::*;

    logic              is_button;
    logic              is_pullup;
    logic              eff_level;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] period;
    logic              reached;
    logic              exceeded;

    assign is_button = cfg.button_mask[idx];
    assign is_pullup = cfg.pullup_mask[idx];
    // pull-up wiring reads low when pressed / on
    assign eff_level = pin_level ^ is_pullup;
    assign elapsed   = now_ms - cur.start_time;
    assign period    = {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
    assign reached   = (elapsed >= period);
    assign exceeded  = (elapsed > period);

    always_comb begin
        nxt      = cur;
        switched = 1'b0;
        if (is_button) begin
            // press start reports once; press cycle ends after the period
            if (eff_level && !cur.pending) begin
                nxt.start_time = now_ms;
                nxt.pending    = 1'b1;
                switched       = 1'b1;
            end else if (cur.pending && exceeded) begin
                nxt.pending = 1'b0;
            end
        end else begin
            // arm on change, flip once the period has elapsed since the change
            if ((eff_level != cur.status) && !cur.pending) begin
                nxt.pending    = 1'b1;
                nxt.start_time = now_ms;
            end else if (cur.pending && reached) begin
                nxt.status  = ~cur.status;
                nxt.pending = 1'b0;
                switched    = 1'b1;
            end
        end
    end

    assign switch_state = nxt.status;

endmodule

/* rtl/core/multi_switch_debouncer_core.sv */
// Top level of the multi-switch debouncer: stream in/out, APB config,
// state table read-modify-write. Depends on dbnc_pkg, dbnc_cfg_regs,
// dbnc_state_ram, dbnc_update.
//
//  Port group | Dir | Word layout (bit 0 up)
//  -----------+-----+------------------------------------------------------
//  s_t*       | in  | switch_index[3:0], pin_level[4], now_ms[36:5], pad
//  m_t*       | out | switched[0], switch_state[1], which_switch[5:2], pad
//  APB p*     | in  | 0x0 debounce_ms, 0x4 button_mask, 0x8 pullup_mask
//
// One sample word per cycle sustained while the output is not stalled; a sample
// goes from input to output register via the table read, then update and
// write-back. Back-to-back samples of the same switch are served by forwarding the last write-back.
// Reset is synchronous; the table reads as zero after reset via per-entry
// valid flags, no clearing pass. A stalled output holds the update stage,
// which in turn drops s_tready.
module multi_switch_debouncer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dbnc_pkg::S_TDATA_W-1:0]  s_tdata,  // switch_index, pin_level, now_ms
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dbnc_pkg::M_TDATA_W-1:0]  m_tdata,  // switched, switch_state, which_switch
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbnc_pkg::APB_AW-1:0]     paddr,
    input  logic [dbnc_pkg::APB_DW-1:0]     pwdata,
    output logic [dbnc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import dbnc_pkg::*;

    localparam int EXT_W = 7;

    dbnc_cfg_t         cfg;
    logic              accept_in;
    logic              advance;

    // input field unpack
    logic [IDX_W-1:0]  in_idx;
    logic              in_level;
    logic [TIME_W-1:0] in_now;
    logic [EXT_W-1:0]  in_idx_ext;

    // update stage
    logic              p1_valid_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic              p1_level_reg;
    logic [TIME_W-1:0] p1_now_reg;
    logic [EXT_W-1:0]  p1_idx_ext;
    logic [ADDR_W-1:0] p1_addr;
    logic              p1_in_range;

    // forwarding of the latest write-back
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    dbnc_entry_t       fwd_data_reg;

    dbnc_entry_t       ram_rd_data;
    dbnc_entry_t       cur_entry;
    dbnc_entry_t       nxt_entry;
    logic              upd_switched;
    logic              upd_state;
    logic              wr_en;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    assign in_idx     = s_tdata[IDX_W-1:0];
    assign in_level   = s_tdata[IDX_W];
    assign in_now     = s_tdata[IDX_W+TIME_W:IDX_W+1];
    assign in_idx_ext = EXT_W'(in_idx);

    // handshake
    assign advance   = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !p1_valid_reg || advance;
    assign accept_in = s_tvalid && s_tready;

    dbnc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbnc_state_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept_in),
        .rd_addr (in_idx_ext[ADDR_W-1:0]),
        .rd_data (ram_rd_data),
        .wr_en   (wr_en),
        .wr_addr (p1_addr),
        .wr_data (nxt_entry)
    );

    // sample capture alongside the table read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept_in) begin
            p1_valid_reg <= 1'b1;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            p1_idx_reg   <= in_idx;
            p1_level_reg <= in_level;
            p1_now_reg   <= in_now;
        end
    end

    assign p1_idx_ext  = EXT_W'(p1_idx_reg);
    assign p1_addr     = p1_idx_ext[ADDR_W-1:0];
    assign p1_in_range = (p1_idx_ext < EXT_W'(NUM_SWITCHES));

    // a write-back on the same edge as this entry's read left the RAM stale
    assign cur_entry = (fwd_valid_reg && (fwd_addr_reg == p1_addr)) ?
                       fwd_data_reg : ram_rd_data;

    dbnc_update u_upd (
        .cfg          (cfg),
        .cur          (cur_entry),
        .idx          (p1_idx_reg),
        .pin_level    (p1_level_reg),
        .now_ms       (p1_now_reg),
        .nxt          (nxt_entry),
        .switched     (upd_switched),
        .switch_state (upd_state)
    );

    assign wr_en = advance && p1_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (wr_en) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_addr_reg <= p1_addr;
            fwd_data_reg <= nxt_entry;
        end
    end

    // output word; out-of-range samples report switched and switch_state as zero
    always_comb begin
        out_data_next                 = '0;
        out_data_next[0]              = p1_in_range && upd_switched;
        out_data_next[1]              = p1_in_range && upd_state;
        out_data_next[IDX_W+1:2]      = p1_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/core/dbnc_checker.sv */
// Port-level checks for the multi-switch debouncer, bound to the top level.
// Depends on dbnc_pkg and multi_switch_debouncer_core.
module dbnc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dbnc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [dbnc_pkg::APB_AW-1:0]     paddr,
    input logic [dbnc_pkg::APB_DW-1:0]     pwdata,
    input logic [dbnc_pkg::APB_DW-1:0]     prdata,
    input logic                            pready
);
    import dbnc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // config port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

    // registers are 16 bits wide
    a_prdata_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[APB_DW-1:CFG_W] == '0)
        else $error("prdata upper bits not zero");

    // debounce period reads back what was just written
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[3:2] == REG_DEBOUNCE) ##1
        (psel && !pwrite && paddr[3:2] == REG_DEBOUNCE)
        |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
        else $error("debounce period readback mismatch");

    // padding bits of the result word stay zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
        else $error("result padding not zero");

endmodule

bind multi_switch_debouncer_core dbnc_checker u_dbnc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

/* verif/multi_switch_debouncer_core_tb.sv */
// Self-checking testbench for multi_switch_debouncer_core: sample words in,
// per-switch debounce results out, checked against a cycle-free predictor.
// Depends on dbnc_pkg and multi_switch_debouncer_core.
`timescale 1ns / 1ps

module multi_switch_debouncer_core_tb;
    import dbnc_pkg::*;

    localparam logic [1:0] REG_UNUSED     = 2'd3;  // decodes to no register
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         LONG_HOLD      = 400;
    localparam int         WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              level;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic             switched;
        logic             switch_state;
        logic [IDX_W-1:0] which_switch;
    } debounce_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // switch_index, pin_level, now_ms
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // switched, switch_state, which_switch
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    multi_switch_debouncer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Predictor copy of the switch table and registers
    logic              sw_status  [NUM_SWITCHES];
    logic              sw_pending [NUM_SWITCHES];
    logic [TIME_W-1:0] sw_start   [NUM_SWITCHES];
    logic [CFG_W-1:0]  cfg_debounce = DEBOUNCE_RST;
    logic [CFG_W-1:0]  cfg_button   = '0;
    logic [CFG_W-1:0]  cfg_pullup   = '0;

    sample_t          pending_samples[$];
    debounce_result_t expected_results[$];
    int               error_count   = 0;
    int unsigned      t_glob        = 0;
    bit               send_hold     = 1'b0;
    bit               long_hold_req = 1'b0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR %s: got 0x%0h, want 0x%0h (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    // Per-switch debounce update; toggles flip after the period, buttons
    // report each press start and re-arm once the period has passed
    function automatic debounce_result_t debounce_predict(sample_t smp);
        debounce_result_t  r;
        logic [TIME_W-1:0] elapsed;
        logic              eff;
        logic [TIME_W-1:0] period;
        r.switched     = 1'b0;
        r.which_switch = smp.idx;
        elapsed        = smp.now_ms - sw_start[smp.idx];
        period         = {{(TIME_W-CFG_W){1'b0}}, cfg_debounce};
        if (cfg_button[smp.idx]) begin
            if (smp.level == ~cfg_pullup[smp.idx] && !sw_pending[smp.idx]) begin
                sw_start[smp.idx]   = smp.now_ms;
                sw_pending[smp.idx] = 1'b1;
                r.switched          = 1'b1;
            end else if (sw_pending[smp.idx] && elapsed > period) begin
                sw_pending[smp.idx] = 1'b0;
            end
        end else begin
            eff = smp.level ^ cfg_pullup[smp.idx];
            if (eff != sw_status[smp.idx] && !sw_pending[smp.idx]) begin
                sw_pending[smp.idx] = 1'b1;
                sw_start[smp.idx]   = smp.now_ms;
            end else if (sw_pending[smp.idx] && elapsed >= period) begin
                sw_status[smp.idx]  = ~sw_status[smp.idx];
                sw_pending[smp.idx] = 1'b0;
                r.switched          = 1'b1;
            end
        end
        r.switch_state = sw_status[smp.idx];
        return r;
    endfunction

    // Sample driver: bursts of random length separated by random gaps
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge aclk) begin : sample_driver
        sample_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 8;
            gap_left   = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (send_hold || pending_samples.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                nxt = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W-S_FIELD_W){1'b0}}, nxt.now_ms, nxt.level, nxt.idx};
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Result receiver: stall mode is redrawn at random from a tick counter; long hold-off on request
    int rx_mode   = 0;
    int rx_tick   = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            rx_tick++;
            if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (rx_tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Scoreboard: results leave before new samples are predicted in the same edge
    always @(posedge aclk) begin : scoreboard
        debounce_result_t want;
        sample_t          smp;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result word", 64'(m_tdata), 64'(0));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.switched)
                        report_mismatch("switched", 64'(m_tdata[0]), 64'(want.switched));
                    if (m_tdata[1] !== want.switch_state)
                        report_mismatch("switch_state", 64'(m_tdata[1]),
                                        64'(want.switch_state));
                    if (m_tdata[5:2] !== want.which_switch)
                        report_mismatch("which_switch", 64'(m_tdata[5:2]),
                                        64'(want.which_switch));
                end
            end
            if (s_tvalid && s_tready) begin
                smp.idx    = s_tdata[IDX_W-1:0];
                smp.level  = s_tdata[IDX_W];
                smp.now_ms = s_tdata[IDX_W+1 +: TIME_W];
                expected_results.push_back(debounce_predict(smp));
            end
        end
    end

    // Watchdog on cycles with no handshake on any port
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", stall_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // APB write, then read back (the unused address is only written)
    task automatic write_register(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 16'hFFFF));
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_DEBOUNCE: cfg_debounce = value;
            REG_BUTTON:   cfg_button   = value;
            REG_PULLUP:   cfg_pullup   = value;
            default:      ;
        endcase
        if (reg_idx != REG_UNUSED) begin
            @(posedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            paddr   <= {reg_idx, 2'b00};
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata[CFG_W-1:0] !== value)
                report_mismatch("register readback", 64'(prdata[CFG_W-1:0]), 64'(value));
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic queue_sample(input int unsigned idx, input bit level, input int unsigned now);
        sample_t smp;
        smp.idx    = idx[IDX_W-1:0];
        smp.level  = level;
        smp.now_ms = now;
        pending_samples.push_back(smp);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed episodes on one switch: an edge, then samples around
    // the period boundary with occasional bounce; the rest is random noise
    task automatic run_random_phase(input int n_items, input int unsigned base_ms);
        int          queued;
        int          followers;
        int unsigned sw;
        int unsigned t0;
        int unsigned off;
        int unsigned deb;
        bit          lvl;
        queued = 0;
        t_glob = base_ms;
        deb    = 32'(cfg_debounce);
        @(negedge aclk);
        while (queued < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_sample($urandom_range(0, NUM_SWITCHES-1), 1'($urandom_range(0, 1)),
                             t_glob + $urandom_range(0, 3*deb + 3));
                queued++;
            end else begin
                sw = $urandom_range(0, NUM_SWITCHES-1);
                lvl = 1'($urandom_range(0, 1));
                t0 = t_glob;
                queue_sample(sw, lvl, t0);
                followers = $urandom_range(1, 4);
                for (int k = 0; k < followers; k++) begin
                    case ($urandom_range(0, 4))
                        0:       off = (deb > 0) ? deb - 1 : 0;
                        1:       off = deb;
                        2:       off = deb + 1;
                        3:       off = $urandom_range(0, deb);
                        default: off = $urandom_range(deb, 2*deb + 2);
                    endcase
                    queue_sample(sw, ($urandom_range(0, 7) == 0) ? !lvl : lvl, t0 + off);
                end
                queued += followers + 1;
                t_glob += deb + $urandom_range(0, 20);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            sw_status[i]  = 1'b0;
            sw_pending[i] = 1'b0;
            sw_start[i]   = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Toggle switches at reset settings: boundary, wrap, bounce while pending
        @(negedge aclk);
        queue_sample(0, 1'b1, 0);
        queue_sample(0, 1'b1, 9);
        queue_sample(0, 1'b1, 10);
        queue_sample(15, 1'b1, 32'hFFFF_FFFA);
        queue_sample(15, 1'b1, 4);
        queue_sample(7, 1'b1, 100);
        queue_sample(7, 1'b0, 105);
        queue_sample(7, 1'b0, 110);
        queue_sample(0, 1'b0, 20);
        queue_sample(0, 1'b0, 32'hFFFF_FFFF);
        queue_sample(4, 1'b1, 50);  // left pending, becomes a button below
        wait_drained();

        // Buttons: period edge is strict, pull-up press reads low, type change
        write_register(REG_DEBOUNCE, 16'd5);
        write_register(REG_BUTTON, 16'h001F);
        write_register(REG_PULLUP, 16'h000A);
        @(negedge aclk);
        queue_sample(0, 1'b1, 1000);
        queue_sample(0, 1'b1, 1003);
        queue_sample(0, 1'b1, 1005);
        queue_sample(0, 1'b1, 1006);
        queue_sample(0, 1'b1, 1007);
        queue_sample(1, 1'b1, 2000);
        queue_sample(1, 1'b0, 2001);
        queue_sample(2, 1'b0, 3000);
        queue_sample(3, 1'b0, 3001);
        queue_sample(4, 1'b0, 52);
        queue_sample(4, 1'b0, 56);
        wait_drained();

        // Zero period, all buttons
        write_register(REG_DEBOUNCE, 16'd0);
        write_register(REG_BUTTON, 16'hFFFF);
        write_register(REG_PULLUP, 16'h0000);
        run_random_phase(230, $urandom);
        wait_drained();

        // Longest period, all pull-up toggles, timer wrapping mid-phase
        write_register(REG_DEBOUNCE, 16'hFFFF);
        write_register(REG_BUTTON, 16'h0000);
        write_register(REG_PULLUP, 16'hFFFF);
        run_random_phase(230, 32'hFFFF_0000);
        wait_drained();

        // Random mix; long receiver hold-off, then a sender pause until drained
        write_register(REG_DEBOUNCE, 16'($urandom_range(1, 40)));
        write_register(REG_BUTTON, 16'($urandom_range(0, 16'hFFFF)));
        write_register(REG_PULLUP, 16'($urandom_range(0, 16'hFFFF)));
        run_random_phase(240, $urandom);
        @(negedge aclk);
        long_hold_req = 1'b1;
        do @(negedge aclk); while (pending_samples.size() > 120);
        send_hold = 1'b1;
        do @(negedge aclk); while (s_tvalid || expected_results.size() != 0);
        send_hold = 1'b0;
        wait_drained();

        // Short period, mixed masks; a write to the unused address changes nothing
        write_register(REG_UNUSED, 16'hFFFF);
        write_register(REG_DEBOUNCE, 16'd3);
        write_register(REG_BUTTON, 16'hA5C3);
        write_register(REG_PULLUP, 16'h3C5A);
        run_random_phase(230, $urandom);
        wait_drained();

        write_register(REG_DEBOUNCE, 16'($urandom_range(0, 64)));
        write_register(REG_BUTTON, 16'($urandom_range(0, 16'hFFFF)));
        write_register(REG_PULLUP, 16'($urandom_range(0, 16'hFFFF)));
        run_random_phase(230, $urandom);
        wait_drained();

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dbnc_pkg.sv
rtl/core/dbnc_cfg_regs.sv
rtl/core/dbnc_state_ram.sv
rtl/core/dbnc_update.sv
rtl/core/multi_switch_debouncer_core.sv
rtl/core/dbnc_checker.sv
verif/multi_switch_debouncer_core_tb.sv
